@@ rtl/tscd_pkg.sv @@
// Shared widths, constants and month table for the TAI to calendar converter.
`default_nettype none
package tscd_pkg;
	localparam int TaiW   = 32;
	localparam int NanoW  = 30;
	localparam int TzW    = 18;
	localparam int OffW   = 9;
	localparam int YearW  = 11;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int HourW  = 5;
	localparam int MinW   = 6;
	localparam int SecW   = 6;

	localparam int NumW   = 31;
	localparam int RemW   = 17;
	localparam int DaysW  = 15;
	localparam int LenW   = 9;
	localparam int SubW   = RemW + 1;

	localparam int MulAW  = 25;
	localparam int MulBW  = 24;
	localparam int ProdW  = MulAW + MulBW;

	// A day is 675 * 2^7 seconds, so the day count is (total >> 7) / 675.
	localparam int DayShift       = 7;
	localparam int DayRemW        = 10;
	localparam int DayRecipShift  = 34;
	localparam int HourShift      = 4;
	localparam int HourRecipShift = 21;
	localparam int RemHourW       = 12;
	localparam int MinShift       = 2;
	localparam int MinRecipShift  = 14;

	localparam logic [OffW-1:0] OffReset = 9'd37;
	localparam logic signed [TzW-1:0] TzLimitPos = 18'sd86400;
	localparam logic signed [TzW-1:0] TzLimitNeg = -18'sd86400;

	// The reciprocals are exact for every operand the datapath can present.
	localparam logic [MulAW-1:0] DayRecip  = 25'd25451659;
	localparam logic [MulAW-1:0] HourRecip = 25'd9321;
	localparam logic [MulAW-1:0] MinRecip  = 25'd1093;

	localparam logic [MulBW-1:0] DayFactor   = 24'd675;
	localparam logic [MulBW-1:0] SecsPerHour = 24'd3600;
	localparam logic [MulBW-1:0] SecsPerMin  = 24'd60;

	localparam logic [YearW-1:0] EpochYear = 11'd1970;
	localparam logic [LenW-1:0] DaysCommon = 9'd365;
	localparam logic [LenW-1:0] DaysLeap   = 9'd366;
	localparam logic [MonthW-1:0] LastMonth = 4'd11;

	// Month index counts from zero, so index one is February.
	function automatic logic [LenW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
		logic [LenW-1:0] d;
		case (m)
			4'd0:    d = 9'd31;
			4'd1:    d = leap ? 9'd29 : 9'd28;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd30;
			4'd4:    d = 9'd31;
			4'd5:    d = 9'd30;
			4'd6:    d = 9'd31;
			4'd7:    d = 9'd31;
			4'd8:    d = 9'd30;
			4'd9:    d = 9'd31;
			4'd10:   d = 9'd30;
			4'd11:   d = 9'd31;
			default: d = 9'd31;
		endcase
		return d;
	endfunction
endpackage
`default_nettype wire

@@ rtl/tscd_in_if.sv @@
// Input channel interface carrying one timestamp per transfer.
`default_nettype none
interface tscd_in_if;
	import tscd_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [TaiW-1:0]          tai_seconds;
	logic [NanoW-1:0]         nanoseconds;
	logic signed [TzW-1:0]    zone_secs;

	modport source (output valid, output tai_seconds, output nanoseconds, output zone_secs,
		input ready);
	modport sink (input valid, input tai_seconds, input nanoseconds, input zone_secs,
		output ready);
endinterface
`default_nettype wire

@@ rtl/tscd_out_if.sv @@
// Output channel interface carrying one calendar date and time per transfer.
`default_nettype none
interface tscd_out_if;
	import tscd_pkg::*;
	logic               valid;
	logic               ready;
	logic [YearW-1:0]   year;
	logic [MonthW-1:0]  month;
	logic [DayW-1:0]    day_of_month;
	logic [HourW-1:0]   hour;
	logic [MinW-1:0]    minute;
	logic [SecW-1:0]    second;
	logic [NanoW-1:0]   nanos_out;

	modport source (output valid, output year, output month, output day_of_month,
		output hour, output minute, output second, output nanos_out, input ready);
	modport sink (input valid, input year, input month, input day_of_month,
		input hour, input minute, input second, input nanos_out, output ready);
endinterface
`default_nettype wire

@@ rtl/tai_seconds_to_calendar_datetime.sv @@
// Top level: TAI seconds to Gregorian date and time of day on a shared multiplier and subtractor.
//
//   channel  direction  handshake       payload
//   in_ch    in         valid/ready     tai_seconds, nanoseconds, zone_secs
//   out_ch   out        valid/ready     year, month, day_of_month, hour, minute, second, nanos_out
//   cfg      in         valid/ready     cfg_data (TAI-UTC offset, reset value 37)
//
// An item goes through six steps on one 25 x 24 bit multiplier, which split the count into
// days, hours, minutes and seconds. The year walk then steps over the whole years after 1970
// (up to 68) and the month walk over the whole months (up to 11), both on the single 18-bit
// subtractor, and they set the rest; they run longest for a date in December 2037.
// The input is ready only when idle.
// The result stays valid until its transfer; a stall on the output holds the block.
// Reset is asynchronous and leaves the block idle with the offset register at 37.
`default_nettype none
module tai_seconds_to_calendar_datetime (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [tscd_pkg::OffW-1:0] cfg_data,
	tscd_in_if.sink                       in_ch,
	tscd_out_if.source                    out_ch
);
	import tscd_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DIV   = 3'd1;
	localparam logic [2:0] S_YEAR  = 3'd2;
	localparam logic [2:0] S_MONTH = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	localparam logic [2:0] ST_DAY       = 3'd0;
	localparam logic [2:0] ST_DAY_BACK  = 3'd1;
	localparam logic [2:0] ST_HOUR      = 3'd2;
	localparam logic [2:0] ST_HOUR_BACK = 3'd3;
	localparam logic [2:0] ST_MIN       = 3'd4;
	localparam logic [2:0] ST_MIN_BACK  = 3'd5;

	logic [2:0]              state_q;
	logic [2:0]              step_q;
	logic [OffW-1:0]         off_q;

	logic [NumW-1:0]         num_q;
	logic [RemW-1:0]         rem_q;
	logic [DaysW-1:0]        days_q;
	logic [YearW-1:0]        year_q;
	logic [MonthW-1:0]       month_q;
	logic [HourW-1:0]        hour_q;
	logic [MinW-1:0]         minute_q;
	logic [SecW-1:0]         second_q;
	logic [NanoW-1:0]        nanos_q;

	logic                    in_fire;
	logic                    out_fire;
	logic signed [TzW-1:0]   tz_c;
	logic [TaiW-1:0]         total;
	logic                    leap;
	logic [MulAW-1:0]        mul_a;
	logic [MulBW-1:0]        mul_b;
	logic [ProdW-1:0]        prod;
	logic [SubW-1:0]         sub_a;
	logic [SubW-1:0]         sub_b;
	logic [SubW:0]           diff;
	logic                    borrow;

	assign cfg_ready = 1'b1;
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_ch.valid = (state_q == S_DONE);
	assign out_fire = out_ch.valid && out_ch.ready;

	always_comb begin
		if (in_ch.zone_secs > TzLimitPos) begin
			tz_c = TzLimitPos;
		end else if (in_ch.zone_secs < TzLimitNeg) begin
			tz_c = TzLimitNeg;
		end else begin
			tz_c = in_ch.zone_secs;
		end
	end

	assign total = in_ch.tai_seconds - {{(TaiW-OffW){off_q[OffW-1]}}, off_q}
		+ {{(TaiW-TzW){tz_c[TzW-1]}}, tz_c};

	// Years reachable from a 31-bit count lie in 1970..2038, where every fourth year is leap.
	assign leap = (year_q[1:0] == 2'b00);

	always_comb begin
		case (step_q)
			ST_DAY: begin
				mul_a = DayRecip;
				mul_b = num_q[NumW-1:DayShift];
			end
			ST_DAY_BACK: begin
				mul_a = {{(MulAW-DaysW){1'b0}}, days_q};
				mul_b = DayFactor;
			end
			ST_HOUR: begin
				mul_a = HourRecip;
				mul_b = {{(MulBW-RemW+HourShift){1'b0}}, rem_q[RemW-1:HourShift]};
			end
			ST_HOUR_BACK: begin
				mul_a = {{(MulAW-HourW){1'b0}}, hour_q};
				mul_b = SecsPerHour;
			end
			ST_MIN: begin
				mul_a = MinRecip;
				mul_b = {{(MulBW-RemHourW+MinShift){1'b0}}, rem_q[RemHourW-1:MinShift]};
			end
			default: begin
				mul_a = {{(MulAW-MinW){1'b0}}, minute_q};
				mul_b = SecsPerMin;
			end
		endcase
	end

	assign prod = {{MulBW{1'b0}}, mul_a} * {{MulAW{1'b0}}, mul_b};

	always_comb begin
		case (state_q)
			S_DIV: begin
				if (step_q == ST_DAY_BACK) begin
					sub_a = {1'b0, num_q[DayShift +: RemW]};
				end else begin
					sub_a = {1'b0, rem_q};
				end
				sub_b = {1'b0, prod[RemW-1:0]};
			end
			S_YEAR: begin
				sub_a = {{(SubW-DaysW){1'b0}}, days_q};
				sub_b = {{(SubW-LenW){1'b0}}, (leap ? DaysLeap : DaysCommon)};
			end
			S_MONTH: begin
				sub_a = {{(SubW-DaysW){1'b0}}, days_q};
				sub_b = {{(SubW-LenW){1'b0}}, month_len(month_q, leap)};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	assign diff = {1'b0, sub_a} - {1'b0, sub_b};
	assign borrow = diff[SubW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= ST_DAY;
			off_q   <= OffReset;
		end else begin
			if (cfg_valid && cfg_ready) begin
				off_q <= cfg_data;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_DIV;
						step_q  <= ST_DAY;
					end
				end
				S_DIV: begin
					if (step_q == ST_MIN_BACK) begin
						state_q <= S_YEAR;
					end else begin
						step_q <= step_q + 3'd1;
					end
				end
				S_YEAR: begin
					if (borrow) begin
						state_q <= S_MONTH;
					end
				end
				S_MONTH: begin
					if (borrow || (month_q == LastMonth)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					num_q   <= total[TaiW-1] ? '0 : total[NumW-1:0];
					nanos_q <= in_ch.nanoseconds;
				end
			end
			S_DIV: begin
				case (step_q)
					ST_DAY: begin
						days_q <= prod[DayRecipShift +: DaysW];
					end
					ST_DAY_BACK: begin
						rem_q <= {diff[DayRemW-1:0], num_q[DayShift-1:0]};
					end
					ST_HOUR: begin
						hour_q <= prod[HourRecipShift +: HourW];
					end
					ST_HOUR_BACK: begin
						rem_q <= diff[RemW-1:0];
					end
					ST_MIN: begin
						minute_q <= prod[MinRecipShift +: MinW];
					end
					default: begin
						second_q <= diff[SecW-1:0];
						year_q   <= EpochYear;
						month_q  <= '0;
					end
				endcase
			end
			S_YEAR: begin
				if (!borrow) begin
					days_q <= diff[DaysW-1:0];
					year_q <= year_q + 11'd1;
				end
			end
			S_MONTH: begin
				if (!borrow && (month_q != LastMonth)) begin
					days_q  <= diff[DaysW-1:0];
					month_q <= month_q + 4'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_ch.year         = year_q;
	assign out_ch.month        = month_q + 4'd1;
	assign out_ch.day_of_month = days_q[DayW-1:0] + 5'd1;
	assign out_ch.hour         = hour_q;
	assign out_ch.minute       = minute_q;
	assign out_ch.second       = second_q;
	assign out_ch.nanos_out    = nanos_q;
endmodule
`default_nettype wire

@@ rtl/tscd_check.sv @@
// Port-level checker for the TAI to calendar converter, bound to the top level.
`default_nettype none
module tscd_check (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [tscd_pkg::MonthW-1:0] month,
	input wire logic [tscd_pkg::DayW-1:0]   day_of_month,
	input wire logic [tscd_pkg::HourW-1:0]  hour,
	input wire logic [tscd_pkg::MinW-1:0]   minute,
	input wire logic [tscd_pkg::SecW-1:0]   second
);
	import tscd_pkg::*;

	// A transfer in starts a conversion, so the next input must wait.
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (!in_ready && !out_valid))
		else $error("input ready or result valid right after an input transfer");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result is pending");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(month) && $stable(day_of_month)
			&& $stable(hour) && $stable(minute) && $stable(second)))
		else $error("stalled result changed or dropped");

	a_fields_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
			&& hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
		else $error("calendar field out of range");
endmodule

bind tai_seconds_to_calendar_datetime tscd_check u_tscd_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.month        (out_ch.month),
	.day_of_month (out_ch.day_of_month),
	.hour         (out_ch.hour),
	.minute       (out_ch.minute),
	.second       (out_ch.second)
);
`default_nettype wire
